// File: design/dbd_pkg.sv
package dbd_pkg;

  // Pyramid geometry
  localparam int NUM_LEVELS = 3;
  localparam int BASE_SHIFT = 3;
  localparam int FRAC_BITS = 8;
  localparam int ONE_PIXEL = 256;
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // Defaults for the top level parameters
  localparam int ANCHORS_PER_CELL_DEF = 2;
  localparam int MAX_GRID_DIM_DEF = 256;
  localparam int QUEUE_DEPTH = 2;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GRID_REG_W = 9;

  // Level codes
  localparam logic [1:0] LEVEL0 = 2'd0;
  localparam logic [1:0] LEVEL1 = 2'd1;
  localparam logic [1:0] LEVEL2 = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH_L0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT_L0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH_L1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT_L1 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH_L2 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT_L2 = 3'd6;

  // Register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd32768;
  localparam logic [GRID_REG_W-1:0] GRID_L0_RST = 9'd80;
  localparam logic [GRID_REG_W-1:0] GRID_L1_RST = 9'd40;
  localparam logic [GRID_REG_W-1:0] GRID_L2_RST = 9'd20;

  typedef struct packed {
    logic [15:0]        score;
    logic signed [15:0] dist_left;
    logic signed [15:0] dist_top;
    logic signed [15:0] dist_right;
    logic signed [15:0] dist_bottom;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         level;
    logic               anchor_index;
    logic signed [23:0] box_x;
    logic signed [23:0] box_y;
    logic signed [23:0] box_width;
    logic signed [23:0] box_height;
    logic [15:0]        box_score;
  } out_item_t;

  typedef struct packed {
    logic [15:0]                            score_threshold;
    logic [NUM_LEVELS-1:0][GRID_REG_W-1:0] grid_width;
    logic [NUM_LEVELS-1:0][GRID_REG_W-1:0] grid_height;
  } cfg_t;

endpackage

// File: design/dbd_queue.sv
module dbd_queue import dbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic [PW-1:0]    wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_nxt;
  logic [CNTW-1:0]  count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNTW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue pushed while full");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(DEPTH)) else $error("queue count past depth");
`endif

endmodule

// File: design/dbd_front.sv
module dbd_front import dbd_pkg::*; #(
  parameter int ANCHORS_PER_CELL = ANCHORS_PER_CELL_DEF,
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     accept,
  input  in_item_t item,
  output logic     q_push,
  output logic [$bits(in_item_t) + 3 + 2 * $clog2(MAX_GRID_DIM) - 1:0] q_data
);

  localparam int CW = $clog2(MAX_GRID_DIM);
  localparam int DW = CW + 1;
  localparam int EW = (DW > GRID_REG_W) ? DW : GRID_REG_W;
  localparam int AW = (ANCHORS_PER_CELL > 1) ? $clog2(ANCHORS_PER_CELL) : 1;

  logic [1:0]    lv_r;
  logic [AW-1:0] anc_r;
  logic [CW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [1:0]    lv_nxt;
  logic [AW-1:0] anc_nxt;
  logic [CW-1:0] row_nxt;
  logic [CW-1:0] col_nxt;
  logic [1:0]    lv_sel;
  logic [DW-1:0] grid_w;
  logic [DW-1:0] grid_h;
  logic          col_last;
  logic          row_last;
  logic          anc_last;

  // Clamp a grid register to the supported range
  function automatic logic [DW-1:0] eff_dim(input logic [GRID_REG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve == '0) begin
      return DW'(1);
    end else if (ve > EW'(MAX_GRID_DIM)) begin
      return DW'(MAX_GRID_DIM);
    end else begin
      return DW'(ve);
    end
  endfunction

  assign lv_sel = (lv_r < 2'(NUM_LEVELS)) ? lv_r : LEVEL0;
  assign grid_w = eff_dim(cfg.grid_width[lv_sel]);
  assign grid_h = eff_dim(cfg.grid_height[lv_sel]);

  assign col_last = !((DW'(col_r) + 1'b1) < grid_w);
  assign row_last = !((DW'(row_r) + 1'b1) < grid_h);
  assign anc_last = !(((AW + 1)'(anc_r) + 1'b1) < (AW + 1)'(ANCHORS_PER_CELL));

  // Keep only requests at or above the threshold
  assign q_push = accept && (item.score >= cfg.score_threshold);
  assign q_data = {item, lv_sel, anc_r[0], row_r, col_r};

  // Walk columns, rows, anchor planes, then levels
  always_comb begin
    lv_nxt  = lv_r;
    anc_nxt = anc_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (!col_last) begin
        col_nxt = col_r + 1'b1;
      end else begin
        col_nxt = '0;
        if (!row_last) begin
          row_nxt = row_r + 1'b1;
        end else begin
          row_nxt = '0;
          if (!anc_last) begin
            anc_nxt = anc_r + 1'b1;
          end else begin
            anc_nxt = '0;
            lv_nxt  = (lv_sel == LEVEL2) ? LEVEL0 : lv_sel + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r  <= LEVEL0;
      anc_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      lv_r  <= lv_nxt;
      anc_r <= anc_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    lv_r < 2'(NUM_LEVELS)) else $error("level counter out of range");
  a_row_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !col_last |=> row_r == $past(row_r) && lv_r == $past(lv_r))
    else $error("row or level moved before the column wrapped");
`endif

endmodule

// File: design/dbd_back.sv
module dbd_back import dbd_pkg::*; #(
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  logic [$bits(in_item_t) + 3 + 2 * $clog2(MAX_GRID_DIM) - 1:0] q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam int CW = $clog2(MAX_GRID_DIM);
  localparam int CALC_W = ((CW + 14 > 23) ? CW + 14 : 23) + 1;
  localparam logic signed [CALC_W-1:0] SAT_HI = CALC_W'(OUT_MAX);
  localparam logic signed [CALC_W-1:0] SAT_LO = CALC_W'(OUT_MIN);

  in_item_t                  item;
  logic [1:0]                lv;
  logic                      anc;
  logic [CW-1:0]             row;
  logic [CW-1:0]             col;
  logic [2:0]                shamt;
  logic signed [CALC_W-1:0]  cx;
  logic signed [CALC_W-1:0]  cy;
  logic signed [CALC_W-1:0]  dl;
  logic signed [CALC_W-1:0]  dt;
  logic signed [CALC_W-1:0]  dr;
  logic signed [CALC_W-1:0]  db;
  out_item_t                 box;
  logic                      out_valid_r;
  out_item_t                 out_item_r;
  logic                      take;

  function automatic logic signed [23:0] sat24(input logic signed [CALC_W-1:0] v);
    if (v > SAT_HI) begin
      return 24'(SAT_HI);
    end else if (v < SAT_LO) begin
      return 24'(SAT_LO);
    end else begin
      return 24'(v);
    end
  endfunction

  assign {item, lv, anc, row, col} = q_data;

  // Stride is a shift by three plus the level
  always_comb begin
    case (lv)
      LEVEL0:  shamt = 3'(BASE_SHIFT);
      LEVEL1:  shamt = 3'(BASE_SHIFT + 1);
      LEVEL2:  shamt = 3'(BASE_SHIFT + 2);
      default: shamt = 3'(BASE_SHIFT);
    endcase
  end

  // Scale the cell position and distances to pixels
  always_comb begin
    cx = (CALC_W'(col) << shamt) << FRAC_BITS;
    cy = (CALC_W'(row) << shamt) << FRAC_BITS;
    dl = CALC_W'(item.dist_left) <<< shamt;
    dt = CALC_W'(item.dist_top) <<< shamt;
    dr = CALC_W'(item.dist_right) <<< shamt;
    db = CALC_W'(item.dist_bottom) <<< shamt;
    box.level        = lv;
    box.anchor_index = anc;
    box.box_x        = sat24(cx - dl);
    box.box_y        = sat24(cy - dt);
    box.box_width    = sat24(dl + dr + CALC_W'(ONE_PIXEL));
    box.box_height   = sat24(dt + db + CALC_W'(ONE_PIXEL));
    box.box_score    = item.score;
  end

  // Load the output register when it is free or being drained
  assign take      = q_valid && (!out_valid_r || out_pop);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= box;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> out_valid_r && out_item_r == $past(out_item_r))
    else $error("pending result changed while stalled");
`endif

endmodule

// File: design/detector_box_decode.sv
// Anchor-free box decoder for a three-level detector pyramid.
//
// Input channel (in_push / in_full / in_data): one head output per grid
// position, in order level 0..2, anchor plane, row, column. The block keeps
// its own position counters; every accepted request advances them, and only
// requests whose score reaches the threshold produce a box.
// Result channel (out_empty / out_pop / out_data): boxes in input order.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// cfg_ready is always high; write only while the block is idle.
//
// An accepted request is registered in the queue, its box then in the output
// register, and empty drops. Throughput: one request per cycle while in_full
// is low, set by the combinational threshold test and shift-add box datapath.
// A two-entry queue separates the classifier from the box stage, and the
// result sits in an output register.
// Reset restores the register defaults and restarts the walk at level 0,
// plane 0, row 0, column 0, with queue and output empty.
// When the receiver stalls, the result holds, the queue fills, and in_full
// rises; requests below threshold pass freely until the queue is full.
module detector_box_decode import dbd_pkg::*; #(
  parameter int ANCHORS_PER_CELL = ANCHORS_PER_CELL_DEF,
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  in_item_t               in_data,
  output logic                   out_empty,
  input  logic                   out_pop,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int QW = $bits(in_item_t) + 3 + 2 * $clog2(MAX_GRID_DIM);

  cfg_t          cfg_r;
  logic          accept;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_head;
  logic          out_valid;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign out_empty = !out_valid;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.score_threshold <= THRESHOLD_RST;
      cfg_r.grid_width      <= {GRID_L2_RST, GRID_L1_RST, GRID_L0_RST};
      cfg_r.grid_height     <= {GRID_L2_RST, GRID_L1_RST, GRID_L0_RST};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCORE_THRESHOLD: cfg_r.score_threshold <= cfg_data;
        REG_GRID_WIDTH_L0:   cfg_r.grid_width[0]   <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_HEIGHT_L0:  cfg_r.grid_height[0]  <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_WIDTH_L1:   cfg_r.grid_width[1]   <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_HEIGHT_L1:  cfg_r.grid_height[1]  <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_WIDTH_L2:   cfg_r.grid_width[2]   <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_HEIGHT_L2:  cfg_r.grid_height[2]  <= cfg_data[GRID_REG_W-1:0];
        default: ;
      endcase
    end
  end

  dbd_front #(
    .ANCHORS_PER_CELL(ANCHORS_PER_CELL),
    .MAX_GRID_DIM(MAX_GRID_DIM)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .accept(accept),
    .item(in_data),
    .q_push(q_push),
    .q_data(q_push_data)
  );

  dbd_queue #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(QW)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data(q_push_data),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_valid),
    .head_data(q_head)
  );

  dbd_back #(
    .MAX_GRID_DIM(MAX_GRID_DIM)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_data(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_pop(out_pop),
    .out_item(out_data)
  );

endmodule

// File: tb/sv/tb_detector_box_decode.sv
`timescale 1ns / 100ps

module tb_detector_box_decode;
  import dbd_pkg::*;

  // Index outside the register map; writes to it change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES = 8;

  // Predicts the boxes of the decoder and holds the ones not yet popped
  class box_scoreboard;
    out_item_t boxes_due[$];
    logic [15:0] threshold;
    logic [GRID_REG_W-1:0] grid_dims[6];
    int level_idx;
    int plane;
    int row;
    int col;
    int failures;
    int reported;

    function new();
      threshold = THRESHOLD_RST;
      grid_dims = '{GRID_L0_RST, GRID_L0_RST, GRID_L1_RST, GRID_L1_RST,
                    GRID_L2_RST, GRID_L2_RST};
      level_idx = 0;
      plane = 0;
      row = 0;
      col = 0;
      failures = 0;
      reported = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCORE_THRESHOLD: threshold = data;
        REG_GRID_WIDTH_L0, REG_GRID_HEIGHT_L0, REG_GRID_WIDTH_L1,
        REG_GRID_HEIGHT_L1, REG_GRID_WIDTH_L2, REG_GRID_HEIGHT_L2: begin
          grid_dims[int'(idx) - 1] = data[GRID_REG_W-1:0];
        end
        default: ;
      endcase
    endfunction

    // Zero reads as one, anything past the maximum as the maximum
    function int grid_size(logic [GRID_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_GRID_DIM_DEF) return MAX_GRID_DIM_DEF;
      return int'(v);
    endfunction

    function logic signed [23:0] clamp24(longint v);
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return v[23:0];
    endfunction

    // Advance the walk: column, row, anchor plane, level, then wrap to level 0
    function void step_position();
      int w;
      int h;
      w = grid_size(grid_dims[level_idx * 2]);
      h = grid_size(grid_dims[level_idx * 2 + 1]);
      if (col + 1 < w) begin
        col++;
        return;
      end
      col = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      row = 0;
      if (plane + 1 < ANCHORS_PER_CELL_DEF) begin
        plane++;
        return;
      end
      plane = 0;
      level_idx = (level_idx + 1 < NUM_LEVELS) ? level_idx + 1 : 0;
    endfunction

    function void decode_request(in_item_t req);
      out_item_t box;
      longint stride;
      longint cx;
      longint cy;
      longint dl;
      longint dt;
      longint dr;
      longint db;
      if (req.score >= threshold) begin
        stride = longint'(1) << (BASE_SHIFT + level_idx);
        cx = longint'(col) * stride * ONE_PIXEL;
        cy = longint'(row) * stride * ONE_PIXEL;
        dl = longint'($signed(req.dist_left)) * stride;
        dt = longint'($signed(req.dist_top)) * stride;
        dr = longint'($signed(req.dist_right)) * stride;
        db = longint'($signed(req.dist_bottom)) * stride;
        box.level = level_idx[1:0];
        box.anchor_index = plane[0];
        box.box_x = clamp24(cx - dl);
        box.box_y = clamp24(cy - dt);
        box.box_width = clamp24(dl + dr + ONE_PIXEL);
        box.box_height = clamp24(dt + db + ONE_PIXEL);
        box.box_score = req.score;
        boxes_due.insert(boxes_due.size(), box);
      end
      step_position();
    endfunction

    function void check_box(out_item_t got);
      out_item_t exp;
      if (boxes_due.size() == 0) begin
        failures++;
        if (reported < 10) begin
          $display("[%0t] unexpected box: level %0d anchor %0d x %0d y %0d w %0d h %0d s %0d",
                   $realtime, got.level, got.anchor_index, got.box_x, got.box_y,
                   got.box_width, got.box_height, got.box_score);
        end
        reported++;
        return;
      end
      exp = boxes_due.pop_front();
      if (got.level != exp.level || got.anchor_index != exp.anchor_index ||
          got.box_x != exp.box_x || got.box_y != exp.box_y ||
          got.box_width != exp.box_width || got.box_height != exp.box_height ||
          got.box_score != exp.box_score) begin
        failures++;
        if (reported < 10) begin
          $display("[%0t] box mismatch", $realtime);
          $display("  exp: level %0d anchor %0d x %0d y %0d w %0d h %0d s %0d",
                   exp.level, exp.anchor_index, exp.box_x, exp.box_y,
                   exp.box_width, exp.box_height, exp.box_score);
          $display("  got: level %0d anchor %0d x %0d y %0d w %0d h %0d s %0d",
                   got.level, got.anchor_index, got.box_x, got.box_y,
                   got.box_width, got.box_height, got.box_score);
        end
        reported++;
      end
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_scoreboard boxes;
  int requests_sent = 0;
  bit hold_request = 1'b0;

  detector_box_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Idle rates: sender light and receiver heavy, then swapped, then none
  function int sender_idle_pct();
    if (requests_sent < 230) return 28;
    if (requests_sent < 460) return 75;
    return 0;
  endfunction

  function int receiver_idle_pct();
    if (requests_sent < 230) return 75;
    if (requests_sent < 460) return 28;
    return 0;
  endfunction

  function in_item_t make_item(logic [15:0] s, logic [15:0] l, logic [15:0] t,
                               logic [15:0] r, logic [15:0] b);
    in_item_t it;
    it.score = s;
    it.dist_left = l;
    it.dist_top = t;
    it.dist_right = r;
    it.dist_bottom = b;
    return it;
  endfunction

  function logic [15:0] pick_dist();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Scores cluster around the threshold so both outcomes stay frequent
  function in_item_t make_request(logic [15:0] thr);
    int s;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) s = $urandom_range(0, 65535);
    else if (pick < 8) s = int'(thr) + int'($urandom_range(0, 4)) - 2;
    else if (pick == 8) s = 0;
    else s = 65535;
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return make_item(s[15:0], pick_dist(), pick_dist(), pick_dist(), pick_dist());
  endfunction

  function logic [GRID_REG_W-1:0] pick_dim();
    return GRID_REG_W'($urandom_range(0, 6));
  endfunction

  // Offer one request, idling at random first, and note it once accepted
  task automatic send_request(in_item_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_full);
    boxes.decode_request(req);
    requests_sent++;
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    boxes.write_reg(idx, data);
  endtask

  // Grid writes carry random upper bits, which the register drops
  task automatic cfg_grid(logic [CFG_INDEX_W-1:0] idx, logic [GRID_REG_W-1:0] dim);
    logic [CFG_DATA_W-1:0] data;
    data = 16'($urandom);
    data[GRID_REG_W-1:0] = dim;
    cfg_write(idx, data);
  endtask

  task automatic cfg_all(logic [15:0] thr, logic [GRID_REG_W-1:0] w0, h0, w1, h1, w2, h2);
    cfg_write(REG_SCORE_THRESHOLD, thr);
    cfg_grid(REG_GRID_WIDTH_L0, w0);
    cfg_grid(REG_GRID_HEIGHT_L0, h0);
    cfg_grid(REG_GRID_WIDTH_L1, w1);
    cfg_grid(REG_GRID_HEIGHT_L1, h1);
    cfg_grid(REG_GRID_WIDTH_L2, w2);
    cfg_grid(REG_GRID_HEIGHT_L2, h2);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the request line, drain every box, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    in_push <= 1'b0;
    while (boxes.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] thr, logic [GRID_REG_W-1:0] w0, h0, w1, h1, w2, h2,
                           int count, bit stall_receiver);
    cfg_all(thr, w0, h0, w1, h1, w2, h2);
    if (stall_receiver) hold_request = 1'b1;
    repeat (count) send_request(make_request(thr));
    quiesce();
  endtask

  // Receiver: pop at random, with one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) boxes.check_box(out_data);
    end
  end

  initial begin : timeout
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int failures;
    boxes = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: threshold edges and distance extremes at level 0
    send_request(make_item(16'd32767, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_item(16'd32768, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_item(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_request(make_item(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_request(make_item(16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    send_request(make_item(16'd40000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001));
    send_request(make_item(16'hFFFF, 16'hFFFF, 16'h0100, 16'h7FFF, 16'h8000));
    quiesce();

    // Tiny grids, zero sizes and an unmapped index; the width drop wraps column 7
    cfg_write(REG_UNMAPPED, 16'($urandom));
    cfg_all(16'h0000, 9'd0, 9'd1, 9'd1, 9'd0, 9'd2, 9'd1);
    for (int i = 0; i < 10; i++) begin
      case (i % 4)
        0: send_request(make_item(16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        1: send_request(make_item(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        2: send_request(make_item(16'h0001, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        default: send_request(make_item(16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
      endcase
    end
    quiesce();

    // Random settings and requests
    run_phase(16'($urandom), pick_dim(), pick_dim(), pick_dim(), pick_dim(),
              pick_dim(), pick_dim(), 50, 1'b0);
    // Oversized level 2 width walks columns up to the maximum
    run_phase(16'h4000, 9'd2, 9'd1, 9'd1, 9'd1, 9'd511, 9'd2, 280, 1'b0);
    // Level 2 shrinks under the live counters; only top scores pass
    run_phase(16'hFFFF, 9'd3, 9'd2, 9'd2, 9'd2, 9'd4, 9'd1, 100, 1'b0);
    // Every request yields a box while the receiver holds off
    run_phase(16'h0000, pick_dim(), pick_dim(), pick_dim(), pick_dim(),
              pick_dim(), pick_dim(), 120, 1'b1);
    // Tall level 0 past the maximum height
    run_phase(16'($urandom), 9'd1, 9'd300, pick_dim(), pick_dim(),
              pick_dim(), pick_dim(), 90, 1'b0);

    failures = boxes.failures + boxes.pending();
    if (boxes.pending() != 0) begin
      $display("%0d boxes never arrived", boxes.pending());
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: detector_box_decode.f
design/dbd_pkg.sv
design/dbd_queue.sv
design/dbd_front.sv
design/dbd_back.sv
design/detector_box_decode.sv
tb/sv/tb_detector_box_decode.sv
